>>> design/bbs_pkg.sv
// Package with the shared types and constants of the brace body scanner.
`default_nettype none
package bbs_pkg;

    localparam int LIMIT_W = 20;
    localparam int COUNT_W = LIMIT_W + 1;

    localparam logic [LIMIT_W-1:0] RESET_MAX_LEN = 20'd65536;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_NONE = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
        logic       end_of_text;
    } t_text_beat;

    typedef struct packed {
        logic [7:0] body_char;
        logic       last_char;
        logic       truncated;
    } t_result;

    typedef struct packed {
        logic       in_str;
        logic       in_chr;
        logic       in_line;
        logic       in_blk;
        logic [7:0] prev;
    } t_mode;

    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage
`default_nettype wire

>>> design/bbs_if.sv
// Valid/ready channel interfaces for text beats and body beats.
`default_nettype none
interface bbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;
    logic       end_of_text;

    modport source(output valid, output ch, output start_req, output end_of_text, input ready);
    modport sink(input valid, input ch, input start_req, input end_of_text, output ready);
endinterface

interface bbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_char;
    logic       last_char;
    logic       truncated;

    modport source(output valid, output body_char, output last_char, output truncated,
                   input ready);
    modport sink(input valid, input body_char, input last_char, input truncated,
                 output ready);
endinterface
`default_nettype wire

>>> design/bbs_scan_core.sv
// Scan state and the per-beat decision logic of the brace body scanner.
`default_nettype none
module bbs_scan_core import bbs_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_text_beat         i_beat,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_push              o_push
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef struct packed {
        t_mode         mode;
        logic [DW-1:0] depth;
        logic          took;
    } t_dec;

    function automatic t_dec decide(t_mode m_in, logic [DW-1:0] d_in,
                                    logic [7:0] c, logic [7:0] nx);
        t_dec r;
        r.mode  = m_in;
        r.depth = d_in;
        r.took  = 1'b0;
        if (!r.mode.in_line && !r.mode.in_blk) begin
            if (c == CH_DQUOTE && r.mode.prev != CH_BSLASH) r.mode.in_str = !r.mode.in_str;
            if (c == CH_SQUOTE && r.mode.prev != CH_BSLASH) r.mode.in_chr = !r.mode.in_chr;
        end
        if (!r.mode.in_str && !r.mode.in_chr) begin
            if (c == CH_SLASH && nx == CH_SLASH) begin
                r.mode.in_line = 1'b1;
            end else if (c == CH_SLASH && nx == CH_STAR) begin
                r.mode.in_blk = 1'b1;
            end else if (r.mode.in_line && c == CH_NEWLINE) begin
                r.mode.in_line = 1'b0;
            end else if (r.mode.in_blk && c == CH_STAR && nx == CH_SLASH) begin
                r.mode.in_blk = 1'b0;
                r.took = 1'b1;
            end
        end
        if (!r.took) begin
            if (!r.mode.in_str && !r.mode.in_chr && !r.mode.in_line && !r.mode.in_blk) begin
                if (c == CH_LBRACE) begin
                    if (r.depth < DW'(MAX_DEPTH)) r.depth = r.depth + DW'(1);
                end else if (c == CH_RBRACE) begin
                    if (r.depth != '0) r.depth = r.depth - DW'(1);
                end
            end
            r.mode.prev = c;
        end
        return r;
    endfunction

    t_mode              r_mode, n_mode;
    logic [DW-1:0]      r_depth, n_depth;
    logic [7:0]         r_held, n_held;
    logic               r_hv, n_hv;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_done, n_done;

    t_mode              s_mode;
    logic [DW-1:0]      s_depth;
    logic               s_hv;
    logic [COUNT_W-1:0] s_cnt;
    logic               active;
    logic [7:0]         c_a;
    logic [7:0]         nx_a;
    t_dec               dec_a;
    t_dec               dec_b;
    logic [COUNT_W-1:0] cnt_a;
    logic [COUNT_W-1:0] cnt_b;
    logic               bal_a;
    logic               over_a;
    logic               bal_b;

    assign s_mode  = i_beat.start_req ? '0 : r_mode;
    assign s_depth = i_beat.start_req ? '0 : r_depth;
    assign s_hv    = i_beat.start_req ? 1'b0 : r_hv;
    assign s_cnt   = i_beat.start_req ? '0 : r_cnt;
    assign active  = i_step && (i_beat.start_req || !r_done);

    assign c_a    = s_hv ? r_held : i_beat.ch;
    assign nx_a   = s_hv ? i_beat.ch : CH_NONE;
    assign dec_a  = decide(s_mode, s_depth, c_a, nx_a);
    assign cnt_a  = s_cnt + (dec_a.took ? COUNT_W'(2) : COUNT_W'(1));
    assign bal_a  = (dec_a.depth == '0);
    assign over_a = (cnt_a > {1'b0, i_limit});
    assign dec_b  = decide(dec_a.mode, dec_a.depth, i_beat.ch, CH_NONE);
    assign cnt_b  = cnt_a + COUNT_W'(1);
    assign bal_b  = (dec_b.depth == '0);

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_held  = r_held;
        n_hv    = r_hv;
        n_cnt   = r_cnt;
        n_done  = r_done;
        o_push.num = 2'd0;
        o_push.r0  = '{body_char: c_a, last_char: 1'b0, truncated: 1'b0};
        o_push.r1  = '{body_char: i_beat.ch, last_char: 1'b0, truncated: 1'b0};
        if (active) begin
            n_done = 1'b0;
            if (!s_hv && !i_beat.end_of_text) begin
                n_mode  = s_mode;
                n_depth = s_depth;
                n_cnt   = s_cnt;
                n_held  = i_beat.ch;
                n_hv    = 1'b1;
            end else begin
                n_mode     = dec_a.mode;
                n_depth    = dec_a.depth;
                n_cnt      = cnt_a;
                o_push.num = dec_a.took ? 2'd2 : 2'd1;
                if (bal_a || over_a || !s_hv) begin
                    n_done = 1'b1;
                    n_hv   = 1'b0;
                    if (dec_a.took) begin
                        o_push.r1.last_char = 1'b1;
                        o_push.r1.truncated = !bal_a;
                    end else begin
                        o_push.r0.last_char = 1'b1;
                        o_push.r0.truncated = !bal_a;
                    end
                end else if (dec_a.took) begin
                    n_hv = 1'b0;
                    if (i_beat.end_of_text) begin
                        n_done = 1'b1;
                        o_push.r1.last_char = 1'b1;
                        o_push.r1.truncated = 1'b1;
                    end
                end else begin
                    n_held = i_beat.ch;
                    n_hv   = 1'b1;
                    if (i_beat.end_of_text) begin
                        n_mode     = dec_b.mode;
                        n_depth    = dec_b.depth;
                        n_cnt      = cnt_b;
                        n_done     = 1'b1;
                        n_hv       = 1'b0;
                        o_push.num = 2'd2;
                        o_push.r1.last_char = 1'b1;
                        o_push.r1.truncated = !bal_b;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_depth <= '0;
            r_held  <= '0;
            r_hv    <= 1'b0;
            r_cnt   <= '0;
            r_done  <= 1'b1;
        end else begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_held  <= n_held;
            r_hv    <= n_hv;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

endmodule
`default_nettype wire

>>> design/bbs_result_queue.sv
// Three-entry result queue that takes up to two results and gives one per beat.
`default_nettype none
module bbs_result_queue import bbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic             o_room,
    bbs_out_if.source        o_body
);

    localparam int QD = 3;
    localparam int CW = $clog2(QD + 1);

    t_result         r_slot [QD];
    t_result         n_slot [QD];
    t_result         sh     [QD];
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   base;
    logic            pop;

    assign pop    = o_body.valid && o_body.ready;
    assign base   = r_cnt - {{(CW-1){1'b0}}, pop};
    assign o_room = (r_cnt <= CW'(1));

    assign o_body.valid     = (r_cnt != '0);
    assign o_body.body_char = r_slot[0].body_char;
    assign o_body.last_char = r_slot[0].last_char;
    assign o_body.truncated = r_slot[0].truncated;

    always_comb begin
        for (int i = 0; i < QD - 1; i++) begin
            sh[i] = pop ? r_slot[i+1] : r_slot[i];
        end
        sh[QD-1] = r_slot[QD-1];
        for (int i = 0; i < QD; i++) begin
            n_slot[i] = sh[i];
            if (i_push.num != 2'd0 && CW'(i) == base) n_slot[i] = i_push.r0;
            if (i_push.num == 2'd2 && CW'(i) == base + CW'(1)) n_slot[i] = i_push.r1;
        end
        n_cnt = base + CW'(i_push.num);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

>>> design/brace_body_scanner_unit.sv
// Top level of the brace body scanner: input register, scan core and result queue.
//
// Text bytes arrive as beats on i_text, the first one of a body marked by start_req
// on its opening brace and the final byte of text marked by end_of_text. Body bytes
// leave as beats on o_body; the final one carries last_char, and truncated when the
// body ended at the length limit or at end of text instead of on the balancing brace.
// The limit is written through i_cfg_we and i_cfg_wdata; the user must do so only
// while the block is idle, since the block itself does not enforce it. A text beat
// is held in the input register and then in the scan core until the next byte
// arrives, and its results are registered in the result queue that drives o_body.
// Each byte is decided when the next one arrives, so the first body byte shows up
// after the second text beat. One text beat enters per cycle while the queue has
// room, and each beat yields at most one body beat; a beat that closes a block
// comment or ends the text can give two, and the input then waits for room again.
// The three-entry result queue decides that room, and it also keeps the input open while the
// receiver stalls with one result waiting.
// After reset the scanner is idle, the limit is 65536, and beats without start_req
// are dropped without a result.
`default_nettype none
module brace_body_scanner_unit import bbs_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bbs_in_if.sink             i_text,
    bbs_out_if.source          o_body,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    logic               r_in_valid, n_in_valid;
    t_text_beat         r_in;
    logic [LIMIT_W-1:0] r_max_len;
    logic               w_room;
    logic               w_step;
    logic               w_take;
    t_push              w_push;

    assign w_step       = r_in_valid && w_room;
    assign i_text.ready = !r_in_valid || w_room;
    assign w_take       = i_text.valid && i_text.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_len  <= RESET_MAX_LEN;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) r_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= '{ch: i_text.ch, start_req: i_text.start_req,
                      end_of_text: i_text.end_of_text};
        end
    end

    bbs_scan_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_beat  (r_in),
        .i_limit (r_max_len),
        .o_push  (w_push)
    );

    bbs_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_body  (o_body)
    );

`ifndef SYNTHESIS
    a_eot_ends_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.end_of_text && w_push.num == 2'd1) |-> w_push.r0.last_char)
        else $error("End of text did not end the body on a single result.");

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num == 2'd2) |-> !w_push.r0.last_char)
        else $error("First of two results was marked as the last byte.");

    a_trunc_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num != 2'd0) |->
        (!w_push.r0.truncated || w_push.r0.last_char) &&
        (!w_push.r1.truncated || w_push.r1.last_char))
        else $error("Truncated flag set on a byte that is not the last.");

    a_valid_falls_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_body.valid) |-> $past(o_body.ready))
        else $error("Output beat vanished without being taken.");
`endif

endmodule
`default_nettype wire
